@@ rtl/rph_pkg.sv @@
package rph_pkg;

   localparam int INTEGRAL_BITS_DEF = 40;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [31:0] RAMP_POINT_RST = 32'd5898840;
   localparam logic [31:0] SOAK_POINT_RST = 32'd11797200;
   localparam logic [31:0] PEAK_POINT_RST = 32'd15729560;
   localparam logic [15:0] GAIN_P_RST     = 16'd512;
   localparam logic [15:0] GAIN_I_RST     = 16'd6;
   localparam logic [15:0] GAIN_D_RST     = 16'd2304;
   localparam logic [7:0]  DRIVE_MAX_RST  = 8'd255;
   localparam logic [7:0]  DRIVE_MIN_RST  = 8'd0;

   localparam logic [15:0] RAMP_MIN_SEC = 16'd90;
   localparam logic [11:0] SP_MAX       = 12'hFFF;
   localparam logic [15:0] FULL_OFF     = 16'hFFFF;
   localparam logic [15:0] DUTY_TOP     = 16'hFF00;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      REG_RAMP_POINT,
      REG_SOAK_POINT,
      REG_PEAK_POINT,
      REG_GAIN_P,
      REG_GAIN_I,
      REG_GAIN_D,
      REG_DRIVE_MAX,
      REG_DRIVE_MIN
   } reg_idx_type;

   typedef struct packed {
      logic [31:0] ramp_point;
      logic [31:0] soak_point;
      logic [31:0] peak_point;
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [7:0]  drive_max;
      logic [7:0]  drive_min;
   } cfg_type;

   typedef struct packed {
      logic [11:0] temp_sample;
      logic [15:0] elapsed_seconds;
   } req_data_type;

   typedef struct packed {
      logic [15:0] heater_duty;
      logic [11:0] target_temp;
      logic [7:0]  drive_level;
      logic        profile_done;
   } rsp_data_type;

   typedef enum logic [2:0] {
      MODE_RAMP,
      MODE_SOAK,
      MODE_REFLOW,
      MODE_DONE,
      MODE_HOLD
   } mode_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_RAMP,
      OP_DIV_RAMP,
      OP_DIV_SEG,
      OP_DIV_STEP,
      OP_SP_RAMP,
      OP_SP_RT,
      OP_MUL_SEG,
      OP_SP_SEG,
      OP_ERR,
      OP_MUL_I,
      OP_INT,
      OP_MUL_P,
      OP_ACC_P,
      OP_MUL_D,
      OP_ACC_D,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     rs_zero;
      logic     out_free;
   } status_type;

endpackage

@@ rtl/rph_csr.sv @@
module rph_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rph_pkg::CSR_AW-1:0]  paddr,
   input  logic [rph_pkg::CSR_DW-1:0]  pwdata,
   output logic [rph_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output rph_pkg::cfg_type            cfg
);
   import rph_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[CSR_AW-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_RAMP_POINT: cfg_in.ramp_point = pwdata;
            REG_SOAK_POINT: cfg_in.soak_point = pwdata;
            REG_PEAK_POINT: cfg_in.peak_point = pwdata;
            REG_GAIN_P:     cfg_in.gain_p     = pwdata[15:0];
            REG_GAIN_I:     cfg_in.gain_i     = pwdata[15:0];
            REG_GAIN_D:     cfg_in.gain_d     = pwdata[15:0];
            REG_DRIVE_MAX:  cfg_in.drive_max  = pwdata[7:0];
            REG_DRIVE_MIN:  cfg_in.drive_min  = pwdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_RAMP_POINT: prdata = cfg_ff.ramp_point;
         REG_SOAK_POINT: prdata = cfg_ff.soak_point;
         REG_PEAK_POINT: prdata = cfg_ff.peak_point;
         REG_GAIN_P:     prdata = {16'h0, cfg_ff.gain_p};
         REG_GAIN_I:     prdata = {16'h0, cfg_ff.gain_i};
         REG_GAIN_D:     prdata = {16'h0, cfg_ff.gain_d};
         REG_DRIVE_MAX:  prdata = {24'h0, cfg_ff.drive_max};
         REG_DRIVE_MIN:  prdata = {24'h0, cfg_ff.drive_min};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_point <= RAMP_POINT_RST;
         cfg_ff.soak_point <= SOAK_POINT_RST;
         cfg_ff.peak_point <= PEAK_POINT_RST;
         cfg_ff.gain_p     <= GAIN_P_RST;
         cfg_ff.gain_i     <= GAIN_I_RST;
         cfg_ff.gain_d     <= GAIN_D_RST;
         cfg_ff.drive_max  <= DRIVE_MAX_RST;
         cfg_ff.drive_min  <= DRIVE_MIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/rph_ctrl.sv @@
module rph_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rph_pkg::status_type status,
   output rph_pkg::cmd_type    cmd
);
   import rph_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECIDE,
      S_MUL_RAMP,
      S_DIV_RAMP,
      S_DIV_SEG,
      S_DIV_RUN,
      S_SP_RAMP,
      S_SP_RT,
      S_MUL_SEG,
      S_SP_SEG,
      S_PID_ERR,
      S_MUL_I,
      S_INT,
      S_MUL_P,
      S_ACC_P,
      S_MUL_D,
      S_ACC_D,
      S_FIN
   } state_type;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      cnt_in   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            unique case (status.mode)
               MODE_RAMP:   state_in = status.rs_zero ? S_SP_RT : S_MUL_RAMP;
               MODE_SOAK,
               MODE_REFLOW: state_in = S_DIV_SEG;
               MODE_DONE:   state_in = S_FIN;
               default:     state_in = S_PID_ERR;
            endcase
         end
         S_MUL_RAMP: begin
            cmd.op   = OP_MUL_RAMP;
            state_in = S_DIV_RAMP;
         end
         S_DIV_RAMP: begin
            cmd.op   = OP_DIV_RAMP;
            state_in = S_DIV_RUN;
         end
         S_DIV_SEG: begin
            cmd.op   = OP_DIV_SEG;
            state_in = S_DIV_RUN;
         end
         S_DIV_RUN: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = (status.mode == MODE_RAMP) ? S_SP_RAMP : S_MUL_SEG;
            end
         end
         S_SP_RAMP: begin
            cmd.op   = OP_SP_RAMP;
            state_in = S_PID_ERR;
         end
         S_SP_RT: begin
            cmd.op   = OP_SP_RT;
            state_in = S_PID_ERR;
         end
         S_MUL_SEG: begin
            cmd.op   = OP_MUL_SEG;
            state_in = S_SP_SEG;
         end
         S_SP_SEG: begin
            cmd.op   = OP_SP_SEG;
            state_in = S_PID_ERR;
         end
         S_PID_ERR: begin
            cmd.op   = OP_ERR;
            state_in = S_MUL_I;
         end
         S_MUL_I: begin
            cmd.op   = OP_MUL_I;
            state_in = S_INT;
         end
         S_INT: begin
            cmd.op   = OP_INT;
            state_in = S_MUL_P;
         end
         S_MUL_P: begin
            cmd.op   = OP_MUL_P;
            state_in = S_ACC_P;
         end
         S_ACC_P: begin
            cmd.op   = OP_ACC_P;
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            cmd.op   = OP_MUL_D;
            state_in = S_ACC_D;
         end
         S_ACC_D: begin
            cmd.op   = OP_ACC_D;
            state_in = S_FIN;
         end
         S_FIN: begin
            // wait for the output register to free up
            if (status.out_free) begin
               cmd.op   = OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_DECIDE)
      else $error("accepted transfer did not start decode");

   a_cnt_div_only: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 |-> state_ff == S_DIV_RUN)
      else $error("divide counter running outside divide");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_FINISH |-> status.out_free)
      else $error("result written into a busy output register");

endmodule

@@ rtl/rph_dp.sv @@
module rph_dp #(
   parameter int INTEGRAL_BITS = rph_pkg::INTEGRAL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rph_pkg::cfg_type      cfg,
   input  rph_pkg::req_data_type req_data,
   input  rph_pkg::cmd_type      cmd,
   output rph_pkg::status_type   status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rph_pkg::rsp_data_type rsp_data
);
   import rph_pkg::*;

   localparam int IB = INTEGRAL_BITS;
   // integral update width: covers both the accumulator and a 34-bit product
   localparam int SW = ((IB > 34) ? IB : 34) + 1;
   localparam logic signed [SW-1:0] I_HI = {{(SW - IB + 1){1'b0}}, {(IB - 1){1'b1}}};
   localparam logic signed [SW-1:0] I_LO = ~I_HI;

   logic [15:0] rt, rs, st, ss, pt, ps;
   logic [15:0] seg_at, seg_bt, seg_as, seg_bs;
   logic [15:0] tin, sin;
   mode_type    mode_in;

   logic [11:0]            t_ff;
   logic [15:0]            s_ff;
   mode_type               mode_ff;
   logic [11:0]            sp_ff;
   logic signed [IB-1:0]   integ_ff;
   logic signed [13:0]     perr_ff;
   logic signed [12:0]     err_ff;
   logic signed [33:0]     prod_ff;
   logic signed [34:0]     acc_ff;
   logic [15:0]            rem_ff, den_ff;
   logic [31:0]            dq_ff;
   logic                   rsp_valid_ff;
   rsp_data_type           rsp_ff;

   logic signed [16:0]     mul_a, mul_b;
   logic signed [33:0]     mul_p;
   logic signed [14:0]     derr;
   logic [16:0]            trial;
   logic                   trial_ge;
   logic [31:0]            q_min;
   logic [32:0]            seg_val;
   logic signed [SW-1:0]   isum;
   logic signed [SW:0]     total, mx, mn;
   logic [15:0]            drive;
   logic                   out_free;

   assign rt = cfg.ramp_point[15:0];
   assign rs = cfg.ramp_point[31:16];
   assign st = cfg.soak_point[15:0];
   assign ss = cfg.soak_point[31:16];
   assign pt = cfg.peak_point[15:0];
   assign ps = cfg.peak_point[31:16];

   assign tin = {4'h0, req_data.temp_sample};
   assign sin = req_data.elapsed_seconds;

   always_comb begin
      if (tin < rt || sin < RAMP_MIN_SEC) begin
         mode_in = MODE_RAMP;
      end else if (tin > rt && tin < st && sin > rs && sin < ss) begin
         mode_in = MODE_SOAK;
      end else if (tin > st && tin < pt && sin > ss && sin < ps) begin
         mode_in = MODE_REFLOW;
      end else if (tin > pt || sin > ps) begin
         mode_in = MODE_DONE;
      end else begin
         mode_in = MODE_HOLD;
      end
   end

   always_comb begin
      if (mode_ff == MODE_SOAK) begin
         seg_at = rt;
         seg_bt = st;
         seg_as = rs;
         seg_bs = ss;
      end else begin
         seg_at = st;
         seg_bt = pt;
         seg_as = ss;
         seg_bs = ps;
      end
   end

   assign derr = 15'(err_ff) - 15'(perr_ff);

   // shared multiplier, operands chosen by the current step
   always_comb begin
      case (cmd.op)
         OP_MUL_RAMP: begin
            mul_a = {1'b0, s_ff};
            mul_b = {1'b0, rt};
         end
         OP_MUL_SEG: begin
            mul_a = {1'b0, s_ff - seg_as};
            mul_b = {1'b0, dq_ff[15:0]};
         end
         OP_MUL_I: begin
            mul_a = {1'b0, cfg.gain_i};
            mul_b = 17'(err_ff);
         end
         OP_MUL_P: begin
            mul_a = {1'b0, cfg.gain_p};
            mul_b = 17'(err_ff);
         end
         OP_MUL_D: begin
            mul_a = {1'b0, cfg.gain_d};
            mul_b = 17'(derr);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // restoring divide, one quotient bit per step
   assign trial    = {rem_ff, dq_ff[31]};
   assign trial_ge = trial >= {1'b0, den_ff};

   assign q_min   = (dq_ff < {16'h0, rt}) ? dq_ff : {16'h0, rt};
   assign seg_val = {1'b0, prod_ff[31:0]} + {17'h0, seg_at};

   assign isum  = SW'(integ_ff) + SW'(prod_ff);
   assign total = (SW + 1)'(integ_ff) + (SW + 1)'(acc_ff);
   assign mx    = {{(SW - 15){1'b0}}, cfg.drive_max, 8'h00};
   assign mn    = {{(SW - 15){1'b0}}, cfg.drive_min, 8'h00};

   always_comb begin
      if (total > mx) begin
         drive = mx[15:0];
      end else if (total < mn) begin
         drive = mn[15:0];
      end else begin
         drive = total[15:0];
      end
   end

   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign status.mode     = mode_ff;
   assign status.rs_zero  = (rs == 16'h0);
   assign status.out_free = out_free;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            t_ff    <= req_data.temp_sample;
            s_ff    <= req_data.elapsed_seconds;
            mode_ff <= mode_in;
         end
         OP_DIV_RAMP: begin
            dq_ff  <= prod_ff[31:0];
            den_ff <= rs;
            rem_ff <= '0;
         end
         OP_DIV_SEG: begin
            dq_ff  <= {16'h0, seg_bt - seg_at};
            den_ff <= seg_bs - seg_as;
            rem_ff <= '0;
         end
         OP_DIV_STEP: begin
            rem_ff <= trial_ge ? 16'(trial - {1'b0, den_ff}) : trial[15:0];
            dq_ff  <= {dq_ff[30:0], trial_ge};
         end
         OP_MUL_RAMP, OP_MUL_SEG, OP_MUL_I, OP_MUL_P, OP_MUL_D: begin
            prod_ff <= mul_p;
         end
         OP_ERR: begin
            err_ff <= $signed({1'b0, sp_ff}) - $signed({1'b0, t_ff});
         end
         OP_ACC_P: begin
            acc_ff <= 35'(prod_ff);
         end
         OP_ACC_D: begin
            acc_ff <= acc_ff + 35'(prod_ff);
         end
         OP_FINISH: begin
            if (mode_ff == MODE_DONE) begin
               rsp_ff.heater_duty  <= FULL_OFF;
               rsp_ff.target_temp  <= '0;
               rsp_ff.drive_level  <= '0;
               rsp_ff.profile_done <= 1'b1;
            end else begin
               rsp_ff.heater_duty  <= DUTY_TOP - drive;
               rsp_ff.target_temp  <= sp_ff;
               rsp_ff.drive_level  <= drive[15:8];
               rsp_ff.profile_done <= 1'b0;
            end
         end
         default: ;
      endcase
   end

   // PID and setpoint state
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff    <= '0;
         integ_ff <= '0;
         perr_ff  <= '0;
      end else begin
         case (cmd.op)
            OP_SP_RAMP: sp_ff <= (q_min > 32'(SP_MAX)) ? SP_MAX : q_min[11:0];
            OP_SP_RT:   sp_ff <= (rt > 16'(SP_MAX)) ? SP_MAX : rt[11:0];
            OP_SP_SEG:  sp_ff <= (seg_val > 33'(SP_MAX)) ? SP_MAX : seg_val[11:0];
            OP_INT: begin
               if (isum > I_HI) begin
                  integ_ff <= I_HI[IB-1:0];
               end else if (isum < I_LO) begin
                  integ_ff <= I_LO[IB-1:0];
               end else begin
                  integ_ff <= isum[IB-1:0];
               end
            end
            OP_FINISH: begin
               if (mode_ff == MODE_DONE) begin
                  sp_ff <= '0;
               end else begin
                  perr_ff <= 14'(err_ff);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_FINISH) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_FINISH |=> rsp_valid_ff)
      else $error("finished result not presented");

   a_done_clears_sp: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_FINISH && mode_ff == MODE_DONE |=> sp_ff == '0)
      else $error("setpoint not cleared after profile end");

   a_done_full_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.profile_done |-> rsp_ff.heater_duty == FULL_OFF)
      else $error("heater not off on finished profile");

endmodule

@@ rtl/reflow_profile_pid_heater_top.sv @@
// Reflow profile PID heater controller. Each sample transfer (temperature in quarter
// degrees and elapsed seconds) yields one result: setpoint, clamped drive, inverted
// 16-bit PWM duty and a done flag. One sample is processed at a time. Work on a sample
// on a ramp or soak/reflow segment is dominated by the 32-step restoring divider and
// the shared 17x17 multiplier that the PID terms pass through one after another; a
// held setpoint and a zero ramp second skip the divider, and a finished profile skips
// the PID terms as well. A new sample is taken while the previous result is still
// waiting at the output. Integral state saturates at INTEGRAL_BITS.
module reflow_profile_pid_heater_top #(
   parameter int INTEGRAL_BITS = rph_pkg::INTEGRAL_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  rph_pkg::req_data_type       req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rph_pkg::rsp_data_type       rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rph_pkg::CSR_AW-1:0]  paddr,
   input  logic [rph_pkg::CSR_DW-1:0]  pwdata,
   output logic [rph_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import rph_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   rph_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rph_dp #(
      .INTEGRAL_BITS (INTEGRAL_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
